// ===== hdl/assert_macros.svh =====
// Assertion helpers for the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define TTD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define TTD_ASSERT_IMP(lbl, ante, cons, msg) \
    `TTD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== hdl/ttd_pkg.sv =====
package ttd_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 15;
    localparam int SPEED_W   = 7;
    localparam int DIR_W     = 2;
    localparam int CFG_IDX_W = 1;

    // Averaging window
    localparam int WINDOW_LEN = 5;
    localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int LEN_LOG    = $clog2(WINDOW_LEN);
    localparam int SUM_W      = SAMPLE_W + LEN_LOG;
    localparam int MAG_W      = SUM_W;

    // Divide by WINDOW_LEN as multiply by a rounded-up reciprocal; exact for |sum| range.
    localparam int AVG_SHIFT = 15 + 2 * LEN_LOG;
    localparam int RECIP     = ((1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam int AVG_W     = SAMPLE_W;

    // Speed mapping
    localparam int SPEED_FULL = 100;
    localparam int QUO_W      = SPEED_W;
    localparam int NUM_W      = CFG_W + QUO_W;
    localparam int STEP_W     = $clog2(QUO_W);
    localparam int CNT_W      = (IDX_W > STEP_W) ? IDX_W : STEP_W;

    // Register reset values and indexes
    localparam int DZ_RESET = 2000;
    localparam int FS_RESET = 16000;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 1'd1;

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE = 2'd0,
        DIR_NEG  = 2'd1,
        DIR_POS  = 2'd2
    } dir_t;

    typedef enum logic {
        AXIS_Y = 1'b0,
        AXIS_X = 1'b1
    } axis_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_AVG,
        ST_PREP,
        ST_DIV,
        ST_STORE,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        logic             load;
        logic             accum;
        logic             avg;
        logic             prep;
        logic             step;
        logic             store;
        logic             out_load;
        axis_t            axis;
        logic [IDX_W-1:0] idx;
    } ctl_cmd_t;

    typedef struct packed {
        logic fixed;
    } dp_stat_t;

endpackage

// ===== hdl/ttd_intf.sv =====
interface ttd_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ttd_pkg::SAMPLE_W-1:0]  accel_x;
    logic signed [ttd_pkg::SAMPLE_W-1:0]  accel_y;

    modport source (output valid, output accel_x, output accel_y, input ready);
    modport sink   (input valid, input accel_x, input accel_y, output ready);
endinterface

interface ttd_drive_if;
    logic                          valid;
    logic                          ready;
    logic [ttd_pkg::DIR_W-1:0]     fwd_dir;
    logic [ttd_pkg::SPEED_W-1:0]   fwd_speed;
    logic [ttd_pkg::DIR_W-1:0]     side_dir;
    logic [ttd_pkg::SPEED_W-1:0]   side_speed;
    logic                          halt;

    modport source (output valid, output fwd_dir, output fwd_speed, output side_dir,
                    output side_speed, output halt, input ready);
    modport sink   (input valid, input fwd_dir, input fwd_speed, input side_dir,
                    input side_speed, input halt, output ready);
endinterface

// ===== hdl/ttd_div.sv =====
module ttd_div (
    input  logic                         clk,
    input  logic                         start,
    input  logic                         step,
    input  logic [ttd_pkg::NUM_W-1:0]    num,
    input  logic [ttd_pkg::CFG_W-1:0]    den,
    output logic [ttd_pkg::QUO_W-1:0]    quo
);

    // Restoring divide, one quotient bit per step; caller guarantees quotient < 2^QUO_W.
    logic [ttd_pkg::CFG_W-1:0] rem_reg, rem_next;
    logic [ttd_pkg::QUO_W-1:0] low_reg;
    logic [ttd_pkg::CFG_W-1:0] den_reg;
    logic [ttd_pkg::QUO_W-1:0] quo_reg;
    logic [ttd_pkg::CFG_W:0]   trial;
    logic                      ge;

    always_comb
    begin
        trial    = {rem_reg, low_reg[ttd_pkg::QUO_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? ttd_pkg::CFG_W'(trial - {1'b0, den_reg})
                      : ttd_pkg::CFG_W'(trial);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[ttd_pkg::NUM_W-1:ttd_pkg::QUO_W];
            low_reg <= num[ttd_pkg::QUO_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[ttd_pkg::QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[ttd_pkg::QUO_W-2:0], ge};
        end
    end

    assign quo = quo_reg;

endmodule

// ===== hdl/ttd_dp.sv =====
module ttd_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ttd_pkg::ctl_cmd_t                   cmd,
    output ttd_pkg::dp_stat_t                   stat,
    input  logic                                cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ttd_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [ttd_pkg::SAMPLE_W-1:0] accel_x,
    input  logic signed [ttd_pkg::SAMPLE_W-1:0] accel_y,
    output logic [ttd_pkg::DIR_W-1:0]           fwd_dir,
    output logic [ttd_pkg::SPEED_W-1:0]         fwd_speed,
    output logic [ttd_pkg::DIR_W-1:0]           side_dir,
    output logic [ttd_pkg::SPEED_W-1:0]         side_speed,
    output logic                                halt
);

    logic [ttd_pkg::CFG_W-1:0]           dead_zone_reg;
    logic [ttd_pkg::CFG_W-1:0]           full_scale_reg;
    logic signed [ttd_pkg::SAMPLE_W-1:0] x_win_reg [ttd_pkg::WINDOW_LEN];
    logic signed [ttd_pkg::SAMPLE_W-1:0] y_win_reg [ttd_pkg::WINDOW_LEN];
    logic [ttd_pkg::IDX_W-1:0]           slot_reg;
    logic signed [ttd_pkg::SUM_W-1:0]    sum_x_reg, sum_y_reg;
    logic [ttd_pkg::PROD_W-1:0]          prod_x_reg, prod_y_reg;
    logic                                neg_x_reg, neg_y_reg;
    logic [ttd_pkg::SPEED_W-1:0]         speed_x_reg, speed_y_reg;
    logic [ttd_pkg::DIR_W-1:0]           fwd_dir_reg, side_dir_reg;
    logic [ttd_pkg::SPEED_W-1:0]         fwd_speed_reg, side_speed_reg;
    logic                                halt_reg;

    logic [ttd_pkg::MAG_W-1:0]   abs_x, abs_y;
    logic [ttd_pkg::RECIP_W-1:0] recip;
    logic [ttd_pkg::AVG_W-1:0]   mag_x, mag_y, mag_sel, dz_ext, fs_ext;
    logic                        below, sat;
    logic [ttd_pkg::SPEED_W-1:0] fixed_speed;
    logic [ttd_pkg::CFG_W-1:0]   diff, den;
    logic [ttd_pkg::NUM_W-1:0]   num;
    logic [ttd_pkg::QUO_W-1:0]   quo;

    function automatic logic [ttd_pkg::DIR_W-1:0] dir_of(
        input logic [ttd_pkg::AVG_W-1:0] m,
        input logic                      neg,
        input logic [ttd_pkg::AVG_W-1:0] dz
    );
        logic [ttd_pkg::DIR_W-1:0] d;
        d = ttd_pkg::DIR_NONE;
        if (m > dz)
            d = neg ? ttd_pkg::DIR_NEG : ttd_pkg::DIR_POS;
        return d;
    endfunction

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg  <= ttd_pkg::CFG_W'(ttd_pkg::DZ_RESET);
            full_scale_reg <= ttd_pkg::CFG_W'(ttd_pkg::FS_RESET);
        end
        else if (cfg_we)
        begin
            if (cfg_index == ttd_pkg::CFG_DEAD_ZONE)
                dead_zone_reg <= cfg_data;
            if (cfg_index == ttd_pkg::CFG_FULL_SCALE)
                full_scale_reg <= cfg_data;
        end
    end

    // Sample windows and shared slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ttd_pkg::WINDOW_LEN; i++)
            begin
                x_win_reg[i] <= '0;
                y_win_reg[i] <= '0;
            end
            slot_reg <= '0;
        end
        else if (cmd.load)
        begin
            x_win_reg[slot_reg] <= accel_x;
            y_win_reg[slot_reg] <= accel_y;
            slot_reg <= (slot_reg == ttd_pkg::IDX_W'(ttd_pkg::WINDOW_LEN - 1))
                        ? '0 : slot_reg + 1'b1;
        end
    end

    always_comb
    begin
        abs_x = sum_x_reg[ttd_pkg::SUM_W-1] ? ttd_pkg::MAG_W'(-sum_x_reg)
                                             : ttd_pkg::MAG_W'(sum_x_reg);
        abs_y = sum_y_reg[ttd_pkg::SUM_W-1] ? ttd_pkg::MAG_W'(-sum_y_reg)
                                             : ttd_pkg::MAG_W'(sum_y_reg);
        recip = ttd_pkg::RECIP_W'(ttd_pkg::RECIP);
        mag_x = prod_x_reg[ttd_pkg::AVG_SHIFT +: ttd_pkg::AVG_W];
        mag_y = prod_y_reg[ttd_pkg::AVG_SHIFT +: ttd_pkg::AVG_W];
    end

    // Window sums, then |sum| / WINDOW_LEN
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else if (cmd.accum)
        begin
            sum_x_reg <= sum_x_reg + ttd_pkg::SUM_W'(x_win_reg[cmd.idx]);
            sum_y_reg <= sum_y_reg + ttd_pkg::SUM_W'(y_win_reg[cmd.idx]);
        end

        if (cmd.avg)
        begin
            prod_x_reg <= abs_x * recip;
            prod_y_reg <= abs_y * recip;
            neg_x_reg  <= sum_x_reg[ttd_pkg::SUM_W-1];
            neg_y_reg  <= sum_y_reg[ttd_pkg::SUM_W-1];
        end
    end

    // Speed mapping for the selected axis
    always_comb
    begin
        mag_sel     = (cmd.axis == ttd_pkg::AXIS_X) ? mag_x : mag_y;
        dz_ext      = {1'b0, dead_zone_reg};
        fs_ext      = {1'b0, full_scale_reg};
        below       = (mag_sel < dz_ext);
        sat         = (full_scale_reg <= dead_zone_reg) || (mag_sel >= fs_ext);
        stat.fixed  = below || sat;
        fixed_speed = below ? '0 : ttd_pkg::SPEED_W'(ttd_pkg::SPEED_FULL);
        // Only used when mag is between dz and fs, so the difference fits CFG_W.
        diff        = ttd_pkg::CFG_W'(mag_sel - dz_ext);
        den         = full_scale_reg - dead_zone_reg;
        num         = ttd_pkg::NUM_W'(diff) * ttd_pkg::NUM_W'(ttd_pkg::SPEED_FULL);
    end

    ttd_div u_div (
        .clk   (clk),
        .start (cmd.prep),
        .step  (cmd.step),
        .num   (num),
        .den   (den),
        .quo   (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.prep && stat.fixed)
        begin
            if (cmd.axis == ttd_pkg::AXIS_X)
                speed_x_reg <= fixed_speed;
            else
                speed_y_reg <= fixed_speed;
        end
        else if (cmd.store)
        begin
            if (cmd.axis == ttd_pkg::AXIS_X)
                speed_x_reg <= quo;
            else
                speed_y_reg <= quo;
        end

        if (cmd.out_load)
        begin
            fwd_dir_reg    <= dir_of(mag_y, neg_y_reg, dz_ext);
            side_dir_reg   <= dir_of(mag_x, neg_x_reg, dz_ext);
            fwd_speed_reg  <= speed_y_reg;
            side_speed_reg <= speed_x_reg;
            halt_reg       <= (speed_y_reg == '0) && (speed_x_reg == '0);
        end
    end

    assign fwd_dir    = fwd_dir_reg;
    assign fwd_speed  = fwd_speed_reg;
    assign side_dir   = side_dir_reg;
    assign side_speed = side_speed_reg;
    assign halt       = halt_reg;

endmodule

// ===== hdl/ttd_ctrl.sv =====
module ttd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ttd_pkg::dp_stat_t  stat,
    output ttd_pkg::ctl_cmd_t  cmd
);

    ttd_pkg::ctl_state_t       state_reg, state_next;
    logic [ttd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    ttd_pkg::axis_t            axis_reg, axis_next;
    logic                      out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            axis_reg      <= ttd_pkg::AXIS_Y;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.axis       = axis_reg;
        cmd.idx        = cnt_reg[ttd_pkg::IDX_W-1:0];

        case (state_reg)
            ttd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ttd_pkg::ST_SUM;
                end
            end
            ttd_pkg::ST_SUM:
            begin
                cmd.accum = 1'b1;
                if (cnt_reg == ttd_pkg::CNT_W'(ttd_pkg::WINDOW_LEN - 1))
                begin
                    cnt_next   = '0;
                    state_next = ttd_pkg::ST_AVG;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ttd_pkg::ST_AVG:
            begin
                cmd.avg    = 1'b1;
                axis_next  = ttd_pkg::AXIS_Y;
                state_next = ttd_pkg::ST_PREP;
            end
            ttd_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
                if (!stat.fixed)
                begin
                    cnt_next   = '0;
                    state_next = ttd_pkg::ST_DIV;
                end
                else if (axis_reg == ttd_pkg::AXIS_X)
                    state_next = ttd_pkg::ST_OUT;
                else
                    axis_next = ttd_pkg::AXIS_X;
            end
            ttd_pkg::ST_DIV:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == ttd_pkg::CNT_W'(ttd_pkg::QUO_W - 1))
                    state_next = ttd_pkg::ST_STORE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ttd_pkg::ST_STORE:
            begin
                cmd.store = 1'b1;
                if (axis_reg == ttd_pkg::AXIS_X)
                    state_next = ttd_pkg::ST_OUT;
                else
                begin
                    axis_next  = ttd_pkg::AXIS_X;
                    state_next = ttd_pkg::ST_PREP;
                end
            end
            ttd_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ttd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttd_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/tilt_to_drive_command.sv =====
// Per sample (WINDOW_LEN = 5): accept, WINDOW_LEN sum steps, average, then per axis a
//   PREP step, plus the 7-step shared divider and a store when it runs, and an output load
//   that waits while an undelivered command is held; only then is the next sample taken.
// Divider runs once per axis whose tilt sits between the dead zone and full scale.
// Reset (rst_n, async, active low): windows and slot cleared, dead_zone = 2000,
//   full_scale = 16000, output channel empty.
`include "assert_macros.svh"

module tilt_to_drive_command (
    input  logic                            clk,
    input  logic                            rst_n,
    ttd_sample_if.sink                      samples,
    ttd_drive_if.source                     commands,
    input  logic                            cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttd_pkg::CFG_W-1:0]       cfg_data
);

    // Controller and datapath talk only through these two structs.
    ttd_pkg::ctl_cmd_t cmd;
    ttd_pkg::dp_stat_t stat;

    // Sequencer: IDLE takes a sample transaction, SUM walks the windows, AVG scales the
    // sums, PREP/DIV/STORE map Y then X to a speed, OUT parks the result in the output
    // register. A new sample is taken while that register still waits to be drained.
    ttd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (commands.valid),
        .out_ready (commands.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Windows, sums, reciprocal multiply, dead zone logic, divider, output register.
    ttd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accel_x    (samples.accel_x),
        .accel_y    (samples.accel_y),
        .fwd_dir    (commands.fwd_dir),
        .fwd_speed  (commands.fwd_speed),
        .side_dir   (commands.side_dir),
        .side_speed (commands.side_speed),
        .halt       (commands.halt)
    );

    // Checks
    `TTD_ASSERT(a_cmd_onehot,
        $onehot0({cmd.load, cmd.accum, cmd.avg, cmd.prep, cmd.step, cmd.store, cmd.out_load}),
        "more than one datapath command active")

    `TTD_ASSERT_IMP(a_no_overwrite, cmd.out_load,
        !commands.valid || commands.ready,
        "output register reloaded while holding an undelivered transaction")

    `TTD_ASSERT_IMP(a_halt_match, commands.valid,
        commands.halt == ((commands.fwd_speed == '0) && (commands.side_speed == '0)),
        "halt flag disagrees with speeds")

    `TTD_ASSERT_IMP(a_speed_range, commands.valid,
        (commands.fwd_speed <= ttd_pkg::SPEED_W'(ttd_pkg::SPEED_FULL)) &&
        (commands.side_speed <= ttd_pkg::SPEED_W'(ttd_pkg::SPEED_FULL)),
        "speed above full scale percent")

endmodule

// ===== sim/tilt_to_drive_command_tb.sv =====
`timescale 1ns / 1ps

module tilt_to_drive_command_tb;

    // Run limit in cycles.
    localparam int CYCLE_LIMIT = 600000;
    // Cycles with nothing in flight before a register write goes out.
    localparam int SETTLE_CYCLES = 4;
    // Tail wait after the last command; covers the block's worst-case latency.
    localparam int TAIL_CYCLES = 30;
    // Final stretch of the run, in transactions, where neither side idles.
    localparam int CALM_ITEMS = 150;
    // Long receiver hold-off to back the block up and stall its input.
    localparam int HOLD_AT_CMD = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTED = 50;

    typedef enum logic [1:0] {
        STEP_SAMPLE,
        STEP_REG_WRITE,
        STEP_DRAIN
    } plan_kind_t;

    typedef struct {
        plan_kind_t                           kind;
        logic signed [ttd_pkg::SAMPLE_W-1:0]  ax;
        logic signed [ttd_pkg::SAMPLE_W-1:0]  ay;
        logic [ttd_pkg::CFG_IDX_W-1:0]        reg_idx;
        logic [ttd_pkg::CFG_W-1:0]            reg_val;
    } plan_step_t;

    typedef struct packed {
        ttd_pkg::dir_t                fwd_dir;
        logic [ttd_pkg::SPEED_W-1:0]  fwd_speed;
        ttd_pkg::dir_t                side_dir;
        logic [ttd_pkg::SPEED_W-1:0]  side_speed;
        logic                         halt;
    } drive_cmd_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ttd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ttd_pkg::CFG_W-1:0]     cfg_data;

    ttd_sample_if tilt_ch();
    ttd_drive_if  cmd_ch();

    tilt_to_drive_command DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (tilt_ch),
        .commands  (cmd_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus plan, filled up front, consumed by the driver.
    plan_step_t tilt_plan[$];
    // Commands the block owes us, oldest first.
    drive_cmd_t drive_cmds_due[$];

    // Shadow copy of the block's state and registers.
    logic signed [ttd_pkg::SAMPLE_W-1:0] x_hist[ttd_pkg::WINDOW_LEN];
    logic signed [ttd_pkg::SAMPLE_W-1:0] y_hist[ttd_pkg::WINDOW_LEN];
    int                                  hist_slot;
    logic [ttd_pkg::CFG_W-1:0]           dz_model;
    logic [ttd_pkg::CFG_W-1:0]           fs_model;

    // sent_count / cmds_seen are only updated with NBAs so readers in other
    // processes always see the pre-edge value.
    int sent_count;
    int cmds_seen;
    int samples_planned;
    int error_count;
    int cycle;

    // Register values as seen while building the plan (steers random tilts).
    int plan_dz;
    int plan_fs;

    //--------------------------------------------------------------------
    // Prediction
    //--------------------------------------------------------------------

    // Speed percent from a filtered axis value.
    function automatic logic [ttd_pkg::SPEED_W-1:0] tilt_speed(int avg);
        int mag;
        int dz;
        int fs;
        int pct;
        mag = (avg < 0) ? -avg : avg;
        dz  = dz_model;
        fs  = fs_model;
        if (mag < dz)
            return '0;
        if (fs <= dz)
            return ttd_pkg::SPEED_W'(ttd_pkg::SPEED_FULL);
        pct = (mag - dz) * ttd_pkg::SPEED_FULL / (fs - dz);
        if (pct > ttd_pkg::SPEED_FULL)
            pct = ttd_pkg::SPEED_FULL;
        return ttd_pkg::SPEED_W'(pct);
    endfunction

    // Direction needs the average strictly outside the dead zone.
    function automatic ttd_pkg::dir_t tilt_dir(int avg);
        int dz;
        dz = dz_model;
        if (avg < -dz)
            return ttd_pkg::DIR_NEG;
        if (avg > dz)
            return ttd_pkg::DIR_POS;
        return ttd_pkg::DIR_NONE;
    endfunction

    // Store the pair at the shared slot, average both windows, map to a command.
    function automatic drive_cmd_t predict_drive_cmd(
        logic signed [ttd_pkg::SAMPLE_W-1:0] ax,
        logic signed [ttd_pkg::SAMPLE_W-1:0] ay
    );
        drive_cmd_t cmd;
        int sum_x;
        int sum_y;
        int avg_x;
        int avg_y;
        x_hist[hist_slot] = ax;
        y_hist[hist_slot] = ay;
        sum_x = 0;
        sum_y = 0;
        for (int i = 0; i < ttd_pkg::WINDOW_LEN; i++)
        begin
            sum_x += x_hist[i];
            sum_y += y_hist[i];
        end
        // SV integer divide truncates toward zero, as the block does
        avg_x = sum_x / ttd_pkg::WINDOW_LEN;
        avg_y = sum_y / ttd_pkg::WINDOW_LEN;
        hist_slot = (hist_slot + 1) % ttd_pkg::WINDOW_LEN;

        cmd.fwd_dir    = tilt_dir(avg_y);
        cmd.fwd_speed  = tilt_speed(avg_y);
        cmd.side_dir   = tilt_dir(avg_x);
        cmd.side_speed = tilt_speed(avg_x);
        cmd.halt       = (cmd.fwd_speed == 0) && (cmd.side_speed == 0);
        return cmd;
    endfunction

    task automatic flag_mismatch(string field, int got, int want);
        if (error_count < MAX_PRINTED)
            $display("%0t ns cmd %0d: %s got %0d expected %0d",
                     $time, cmds_seen, field, got, want);
        error_count++;
    endtask

    //--------------------------------------------------------------------
    // Plan building
    //--------------------------------------------------------------------

    task automatic plan_sample(logic signed [ttd_pkg::SAMPLE_W-1:0] ax,
                               logic signed [ttd_pkg::SAMPLE_W-1:0] ay);
        plan_step_t s;
        s.kind    = STEP_SAMPLE;
        s.ax      = ax;
        s.ay      = ay;
        s.reg_idx = ttd_pkg::CFG_DEAD_ZONE;
        s.reg_val = '0;
        tilt_plan.push_back(s);
        samples_planned++;
    endtask

    // Drain the block, then rewrite both registers.
    task automatic plan_regs(int dz, int fs);
        plan_step_t s;
        s.kind = STEP_DRAIN;
        s.ax   = '0;
        s.ay   = '0;
        s.reg_idx = ttd_pkg::CFG_DEAD_ZONE;
        s.reg_val = '0;
        tilt_plan.push_back(s);
        s.kind    = STEP_REG_WRITE;
        s.reg_idx = ttd_pkg::CFG_DEAD_ZONE;
        s.reg_val = ttd_pkg::CFG_W'(dz);
        tilt_plan.push_back(s);
        s.reg_idx = ttd_pkg::CFG_FULL_SCALE;
        s.reg_val = ttd_pkg::CFG_W'(fs);
        tilt_plan.push_back(s);
        plan_dz = dz;
        plan_fs = fs;
    endtask

    function automatic logic signed [ttd_pkg::SAMPLE_W-1:0] clamp16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return ttd_pkg::SAMPLE_W'(v);
    endfunction

    // A tilt level aimed at interesting parts of the speed curve.
    function automatic int pick_tilt();
        int mag;
        case ($urandom_range(0, 4))
            0: mag = plan_dz + int'($urandom_range(0, 4)) - 2;      // dead zone edge
            1: mag = (plan_fs > plan_dz) ? int'($urandom_range(plan_dz, plan_fs))
                                         : int'($urandom_range(0, 32767));
            2: mag = $urandom_range(0, plan_dz);
            3: mag = 32767 + int'($urandom_range(0, 1));            // full deflection
            default: mag = $urandom_range(0, 32768);
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Mostly steady tilts held long enough to fill the window, some raw noise,
    // some slamming between the rails.
    task automatic plan_random_phase(int n);
        int planned;
        int tx;
        int ty;
        int amp;
        int run_len;
        planned = 0;
        while (planned < n)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4:
                begin
                    plan_sample(ttd_pkg::SAMPLE_W'($urandom), ttd_pkg::SAMPLE_W'($urandom));
                    planned++;
                end
                5, 6:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        plan_sample($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000,
                                    $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
                    end
                    planned += 3;
                end
                default:
                begin
                    tx      = pick_tilt();
                    ty      = pick_tilt();
                    amp     = $urandom_range(0, 64);
                    run_len = $urandom_range(ttd_pkg::WINDOW_LEN, 12);
                    for (int i = 0; i < run_len; i++)
                    begin
                        plan_sample(clamp16(tx + int'($urandom_range(0, 2 * amp)) - amp),
                                    clamp16(ty + int'($urandom_range(0, 2 * amp)) - amp));
                    end
                    planned += run_len;
                end
            endcase
        end
    endtask

    //--------------------------------------------------------------------
    // Clock, reset, plan, end of run
    //--------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        int dz_set[6];
        int fs_set[6];

        // All block inputs known from time zero
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = ttd_pkg::CFG_DEAD_ZONE;
        cfg_data      = '0;
        tilt_ch.valid   = 1'b0;
        tilt_ch.accel_x = '0;
        tilt_ch.accel_y = '0;
        cmd_ch.ready    = 1'b0;

        for (int i = 0; i < ttd_pkg::WINDOW_LEN; i++)
        begin
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
        hist_slot       = 0;
        dz_model        = ttd_pkg::CFG_W'(ttd_pkg::DZ_RESET);
        fs_model        = ttd_pkg::CFG_W'(ttd_pkg::FS_RESET);
        plan_dz         = ttd_pkg::DZ_RESET;
        plan_fs         = ttd_pkg::FS_RESET;
        samples_planned = 0;
        error_count     = 0;

        // Directed: reset registers. Idle, both rails held over a full window
        // (the all-minimum case must give exactly 32768), then averages sitting
        // exactly on plus/minus the dead zone.
        plan_sample(16'sd0, 16'sd0);
        for (int i = 0; i < ttd_pkg::WINDOW_LEN; i++)
            plan_sample(16'sh8000, 16'sh8000);
        for (int i = 0; i < ttd_pkg::WINDOW_LEN; i++)
            plan_sample(16'sh7fff, 16'sh7fff);
        for (int i = 0; i < ttd_pkg::WINDOW_LEN; i++)
            plan_sample(16'sd2000, -16'sd2000);

        // Full scale zero: never above the dead zone, everything saturates.
        plan_regs(0, 0);
        plan_sample(16'sd1, -16'sd1);
        plan_sample(16'sd0, 16'sd0);

        // Widest dead zone; only the all-minimum average gets past it.
        plan_regs(32767, 1);
        for (int i = 0; i < ttd_pkg::WINDOW_LEN; i++)
            plan_sample(16'sh8000, 16'sh7fff);

        // Random phases, register extremes first
        dz_set = '{2000, 0, 32767, 100, 5000, 0};
        fs_set = '{16000, 32767, 32767, 300, 1, 0};
        for (int p = 0; p < 12; p++)
        begin
            if (p < 6)
                plan_regs(dz_set[p], fs_set[p]);
            else
                plan_regs($urandom_range(0, 6000), $urandom_range(0, 32767));
            plan_random_phase(152);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (tilt_plan.size() != 0 || tilt_ch.valid || sent_count != cmds_seen);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (drive_cmds_due.size() != 0)
            flag_mismatch("commands never delivered", 0, drive_cmds_due.size());

        if (error_count == 0)
            $display("tilt_to_drive_command_tb: clean");
        else
            $display("tilt_to_drive_command_tb: errors");
        $finish;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT)
        begin
            $display("tilt_to_drive_command_tb: timeout at cycle %0d", cycle);
            $display("tilt_to_drive_command_tb: errors");
            $finish;
        end
    end

    initial cycle = 0;

    //--------------------------------------------------------------------
    // Driver: sample channel and register port
    //--------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : tilt_driver
        plan_step_t step;
        int gap_left;
        int quiet;
        int send_gap_pct;
        bit calm;
        bit cfg_we_next;
        if (!rst_n)
        begin
            tilt_ch.valid <= 1'b0;
            cfg_we        <= 1'b0;
            sent_count    <= 0;
            gap_left      = 0;
            quiet         = 0;
            send_gap_pct  = 10;
        end
        else
        begin
            cfg_we_next = 1'b0;
            calm = tilt_plan.size() < CALM_ITEMS;

            // Reroll how bursty the sender is: some stretches never idle
            if (cycle % 256 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: send_gap_pct = 0;
                    1: send_gap_pct = 10;
                    default: send_gap_pct = 40;
                endcase
            end

            // Nothing in flight and nothing offered -> block is idle
            if (!tilt_ch.valid && sent_count == cmds_seen)
                quiet++;
            else
                quiet = 0;

            if (tilt_ch.valid && tilt_ch.ready)
            begin
                drive_cmds_due.push_back(predict_drive_cmd(tilt_ch.accel_x,
                                                           tilt_ch.accel_y));
                sent_count <= sent_count + 1;
            end

            // An offered transaction stays put until the block takes it
            if (!(tilt_ch.valid && !tilt_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    tilt_ch.valid <= 1'b0;
                end
                else if (tilt_plan.size() == 0)
                begin
                    tilt_ch.valid <= 1'b0;
                end
                else
                begin
                    step = tilt_plan[0];
                    case (step.kind)
                        STEP_SAMPLE:
                        begin
                            if (!calm && $urandom_range(0, 99) < send_gap_pct)
                            begin
                                gap_left = $urandom_range(1, 8) - 1;
                                tilt_ch.valid <= 1'b0;
                            end
                            else
                            begin
                                void'(tilt_plan.pop_front());
                                tilt_ch.valid   <= 1'b1;
                                tilt_ch.accel_x <= step.ax;
                                tilt_ch.accel_y <= step.ay;
                            end
                        end
                        STEP_REG_WRITE:
                        begin
                            tilt_ch.valid <= 1'b0;
                            if (quiet >= SETTLE_CYCLES)
                            begin
                                void'(tilt_plan.pop_front());
                                cfg_we_next = 1'b1;
                                cfg_index <= step.reg_idx;
                                cfg_data  <= step.reg_val;
                                if (step.reg_idx == ttd_pkg::CFG_DEAD_ZONE)
                                    dz_model = step.reg_val;
                                else
                                    fs_model = step.reg_val;
                            end
                        end
                        default:
                        begin
                            // sender pause: hold until every command is back
                            tilt_ch.valid <= 1'b0;
                            if (quiet >= SETTLE_CYCLES)
                                void'(tilt_plan.pop_front());
                        end
                    endcase
                end
            end

            cfg_we <= cfg_we_next;
        end
    end

    //--------------------------------------------------------------------
    // Monitor: command channel, ready pattern and checking
    //--------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : cmd_monitor
        drive_cmd_t want;
        int stall_left;
        int recv_stall_pct;
        bit long_hold_done;
        bit calm;
        if (!rst_n)
        begin
            cmd_ch.ready   <= 1'b0;
            cmds_seen      <= 0;
            stall_left     = 0;
            recv_stall_pct = 10;
            long_hold_done = 1'b0;
        end
        else
        begin
            calm = cmds_seen + CALM_ITEMS >= samples_planned;

            if (cycle % 256 == 128)
            begin
                case ($urandom_range(0, 2))
                    0: recv_stall_pct = 0;
                    1: recv_stall_pct = 10;
                    default: recv_stall_pct = 40;
                endcase
            end

            if (cmd_ch.valid && cmd_ch.ready)
            begin
                if (drive_cmds_due.size() == 0)
                begin
                    flag_mismatch("unexpected command", 1, 0);
                end
                else
                begin
                    want = drive_cmds_due.pop_front();
                    if (cmd_ch.fwd_dir !== want.fwd_dir)
                        flag_mismatch("fwd_dir", cmd_ch.fwd_dir, want.fwd_dir);
                    if (cmd_ch.fwd_speed !== want.fwd_speed)
                        flag_mismatch("fwd_speed", cmd_ch.fwd_speed, want.fwd_speed);
                    if (cmd_ch.side_dir !== want.side_dir)
                        flag_mismatch("side_dir", cmd_ch.side_dir, want.side_dir);
                    if (cmd_ch.side_speed !== want.side_speed)
                        flag_mismatch("side_speed", cmd_ch.side_speed, want.side_speed);
                    if (cmd_ch.halt !== want.halt)
                        flag_mismatch("halt", cmd_ch.halt, want.halt);
                end
                cmds_seen <= cmds_seen + 1;
            end

            // One long hold-off while the sender keeps going: the block backs up
            if (!long_hold_done && cmds_seen == HOLD_AT_CMD)
            begin
                stall_left     = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end

            if (stall_left > 0)
            begin
                stall_left--;
                cmd_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < recv_stall_pct)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                cmd_ch.ready <= 1'b0;
            end
            else
            begin
                cmd_ch.ready <= 1'b1;
            end
        end
    end

endmodule
